>>> hdl/fwc_pkg.sv
// shared types and codes for the tagged fifo with cancel by id
package fwc_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS         = 16;
   localparam int VALUE_BITS      = 32;
   localparam int FUNC_BITS       = 2;
   localparam int STATUS_BITS     = 2;
   localparam int OCC_BITS        = 5;

   // operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_UPDATE  = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_CANCEL  = 2'd3;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [ID_BITS-1:0]    entry_id;
      logic [VALUE_BITS-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0]     result_id;
      logic [VALUE_BITS-1:0]  result_value;
      logic [OCC_BITS-1:0]    occupancy;
   } rsp_type;

   // commands broadcast from the controller to every cell
   typedef struct packed {
      logic compare;
      logic append;
      logic remove;
      logic update;
   } cell_cmd_type;

endpackage

>>> hdl/fwc_cell.sv
// one queue slot: holds an id and a value, matches a key and shifts toward the head
module fwc_cell (
   input  logic                          clock,
   input  fwc_pkg::cell_cmd_type         cmd,
   input  logic                          in_use,
   input  logic                          at_tail,
   input  logic [fwc_pkg::ID_BITS-1:0]    key,
   input  logic [fwc_pkg::ID_BITS-1:0]    new_id,
   input  logic [fwc_pkg::VALUE_BITS-1:0] new_value,
   input  logic [fwc_pkg::ID_BITS-1:0]    next_id,
   input  logic [fwc_pkg::VALUE_BITS-1:0] next_value,
   input  logic                          found_in,
   output logic                          found_out,
   input  logic [fwc_pkg::ID_BITS-1:0]    acc_id_in,
   input  logic [fwc_pkg::VALUE_BITS-1:0] acc_value_in,
   output logic [fwc_pkg::ID_BITS-1:0]    acc_id_out,
   output logic [fwc_pkg::VALUE_BITS-1:0] acc_value_out,
   output logic [fwc_pkg::ID_BITS-1:0]    id_o,
   output logic [fwc_pkg::VALUE_BITS-1:0] value_o
);
   import fwc_pkg::*;

   logic [ID_BITS-1:0]    id_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match_ff;
   logic                  hit;

   // first live match counted from the head
   assign hit       = match_ff & in_use & ~found_in;
   assign found_out = found_in | (match_ff & in_use);

   // gather the matching entry along the chain
   assign acc_id_out    = acc_id_in | (hit ? id_ff : '0);
   assign acc_value_out = acc_value_in | (hit ? value_ff : '0);

   assign id_o    = id_ff;
   assign value_o = value_ff;

   // key compare is registered when the transaction is taken
   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= (id_ff == key);
      end
   end

   // slot contents: append at tail, close the gap, or rewrite the value
   always_ff @(posedge clock) begin
      if (cmd.append && at_tail) begin
         id_ff    <= new_id;
         value_ff <= new_value;
      end else if (cmd.remove && (found_in || hit)) begin
         id_ff    <= next_id;
         value_ff <= next_value;
      end else if (cmd.update && hit) begin
         value_ff <= new_value;
      end
   end

endmodule

>>> hdl/fifo_with_cancel_by_id.sv
// top level of the tagged fifo with cancel by id: controller and row of slot cells
//
// Usage: a request transaction on req_ (valid/stall) carries func, entry_id and
// entry_value. func selects enqueue, dequeue of the head, update of the value of
// the first entry with entry_id, or cancel of that entry. Every request gives
// exactly one response transaction on rsp_ with status, result_id, result_value
// and the occupancy after the operation. Enqueue tags the entry with the next
// id, counting from 1 and wrapping at ID_BITS.
// In the accept cycle every cell registers its key compare; in the execute step
// the first-match chain through the cells selects the entry, the cells shift one
// place toward the head to close a gap, and the response register is loaded.
// req_stall is high while a request is held, so a new one is taken only after
// the last has executed. If rsp_stall holds a finished response, the next
// request is still taken but waits in its execute step until the response
// register frees. Reset empties the queue and restarts the id count; slot
// contents are not cleared, and no clearing pass is needed.
module fifo_with_cancel_by_id #(
   parameter int QUEUE_DEPTH = fwc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fwc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fwc_pkg::rsp_type rsp_data
);
   import fwc_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                  busy_ff;
   req_type               req_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [ID_BITS-1:0]    last_id_ff;
   logic [ID_BITS-1:0]    new_id;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  accept;
   logic                  exec;
   logic                  empty;
   logic                  full;
   logic                  found;
   cell_cmd_type          cmd;

   logic                  found_chain [QUEUE_DEPTH+1];
   logic [ID_BITS-1:0]    acc_id      [QUEUE_DEPTH+1];
   logic [VALUE_BITS-1:0] acc_value   [QUEUE_DEPTH+1];
   logic [ID_BITS-1:0]    cell_id     [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0] cell_value  [QUEUE_DEPTH];

   // handshakes
   assign accept    = req_valid && !busy_ff;
   assign exec      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // queue status
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign new_id = last_id_ff + ID_BITS'(1);
   assign found  = found_chain[QUEUE_DEPTH];

   // a dequeue marks every cell as past the match so the whole row shifts
   assign found_chain[0] = (req_ff.func == FUNC_DEQUEUE);
   assign acc_id[0]      = '0;
   assign acc_value[0]   = '0;

   // commands to the cells
   always_comb begin
      cmd.compare = accept;
      cmd.append  = exec && (req_ff.func == FUNC_ENQUEUE) && !full;
      cmd.remove  = exec && !empty
                    && ((req_ff.func == FUNC_DEQUEUE)
                        || ((req_ff.func == FUNC_CANCEL) && found));
      cmd.update  = exec && !empty && (req_ff.func == FUNC_UPDATE) && found;
   end

   // row of slot cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0]    nb_id;
      logic [VALUE_BITS-1:0] nb_value;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign nb_id    = cell_id[i];
         assign nb_value = cell_value[i];
      end else begin : g_mid
         assign nb_id    = cell_id[i+1];
         assign nb_value = cell_value[i+1];
      end

      fwc_cell u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .in_use        (CNT_W'(i) < count_ff),
         .at_tail       (CNT_W'(i) == count_ff),
         .key           (req_data.entry_id),
         .new_id        (new_id),
         .new_value     (req_ff.entry_value),
         .next_id       (nb_id),
         .next_value    (nb_value),
         .found_in      (found_chain[i]),
         .found_out     (found_chain[i+1]),
         .acc_id_in     (acc_id[i]),
         .acc_value_in  (acc_value[i]),
         .acc_id_out    (acc_id[i+1]),
         .acc_value_out (acc_value[i+1]),
         .id_o          (cell_id[i]),
         .value_o       (cell_value[i])
      );
   end

   // response and new occupancy
   always_comb begin
      count_in                 = count_ff;
      rsp_data_in.status       = STATUS_OK;
      rsp_data_in.result_id    = '0;
      rsp_data_in.result_value = '0;
      case (req_ff.func)
         FUNC_ENQUEUE: begin
            if (full) begin
               rsp_data_in.status = STATUS_FULL;
            end else begin
               rsp_data_in.result_id = new_id;
               count_in              = count_ff + CNT_W'(1);
            end
         end
         FUNC_DEQUEUE: begin
            if (empty) begin
               rsp_data_in.status = STATUS_EMPTY;
            end else begin
               rsp_data_in.result_id    = cell_id[0];
               rsp_data_in.result_value = cell_value[0];
               count_in                 = count_ff - CNT_W'(1);
            end
         end
         FUNC_UPDATE, FUNC_CANCEL: begin
            if (empty) begin
               rsp_data_in.status = STATUS_EMPTY;
            end else if (!found) begin
               rsp_data_in.status = STATUS_NOTFOUND;
            end else begin
               rsp_data_in.result_id    = acc_id[QUEUE_DEPTH];
               rsp_data_in.result_value = acc_value[QUEUE_DEPTH];
               if (req_ff.func == FUNC_CANCEL) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            rsp_data_in.status = STATUS_OK;
         end
      endcase
      rsp_data_in.occupancy = OCC_BITS'(32'(count_in));
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         last_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (exec) begin
            busy_ff <= 1'b0;
         end
         if (exec) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
            if (cmd.append) begin
               last_id_ff <= new_id;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
